// ===== design/sorted_table_binary_search_unit_defines.svh =====
// Assertion macros shared by the sorted table binary search unit
`ifndef SORTED_TABLE_BINARY_SEARCH_UNIT_DEFINES_SVH
`define SORTED_TABLE_BINARY_SEARCH_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define STBS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset
`define STBS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/stbs_pkg.sv =====
// Shared constants and types for the sorted table binary search unit
package stbs_pkg;

   // Fixed field widths
   localparam int VALUE_W    = 32;
   localparam int INDEX_W    = 8;
   localparam int COUNT_W    = 9;
   localparam int POSITION_W = 8;

   // Default table size
   localparam int DEFAULT_TABLE_DEPTH = 256;

   // Item operation codes
   localparam logic OP_WRITE  = 1'b0;
   localparam logic OP_SEARCH = 1'b1;

   // Outcome of one probe step
   typedef struct packed {
      logic hit;
      logic exhausted;
   } probe_status_type;

endpackage

// ===== design/sorted_table_binary_search_unit.sv =====
// Top level of the sorted table binary search unit: sequencer and result register.
// Write beat: no result. Search beat: the accept cycle issues the first read,
// then one probe per cycle, at most ceil(log2(count+1)) probes (nine at 256 entries),
// then the finish state posts the result; a held result beat delays the post.
// Synchronous reset clears the sequencer, result valid and entry count; the table is not cleared.
module sorted_table_binary_search_unit #(
   parameter int TABLE_DEPTH = stbs_pkg::DEFAULT_TABLE_DEPTH
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic                                  req_op,
   input  logic [stbs_pkg::INDEX_W-1:0]          req_entry_index,
   input  logic signed [stbs_pkg::VALUE_W-1:0]   req_value,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic                                  rsp_found,
   output logic [stbs_pkg::POSITION_W-1:0]       rsp_position,
   input  logic                                  csr_wr_en,
   input  logic [stbs_pkg::COUNT_W-1:0]          csr_wr_data
);
   import stbs_pkg::*;

`include "sorted_table_binary_search_unit_defines.svh"

   localparam int ADDR_W = $clog2(TABLE_DEPTH);
   localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_SEARCH = 3'b010,
      ST_FINISH = 3'b100
   } state_type;

   state_type                 state_ff, state_in;
   logic [COUNT_W-1:0]        entry_count_ff;
   logic signed [VALUE_W-1:0] key_ff;
   logic [CNT_W-1:0]          lo_ff, bound_ff;
   logic [ADDR_W-1:0]         mid_ff;
   logic                      found_ff;
   logic [POSITION_W-1:0]     position_ff;
   logic                      rsp_valid_ff;
   logic                      rsp_found_ff;
   logic [POSITION_W-1:0]     rsp_position_ff;

   logic                      accept;
   logic                      start;
   logic                      wr_en;
   logic                      rd_en;
   logic [CNT_W-1:0]          count_sat;
   logic [CNT_W-1:0]          lo_next, bound_next;
   logic [ADDR_W-1:0]         mid_next;
   logic [VALUE_W-1:0]        rd_data;
   probe_status_type          status;
   logic                      post;

   // input handshake and item decode
   assign req_stall = state_ff != ST_IDLE;
   assign accept    = req_valid && !req_stall;
   assign start     = accept && req_op == OP_SEARCH;
   assign wr_en     = accept && req_op == OP_WRITE &&
                      32'(req_entry_index) < 32'(TABLE_DEPTH);
   assign count_sat = (32'(entry_count_ff) > 32'(TABLE_DEPTH)) ?
                      CNT_W'(TABLE_DEPTH) : CNT_W'(entry_count_ff);

   // read the next midpoint whenever the search carries on
   assign rd_en = (start && !status.exhausted) ||
                  (state_ff == ST_SEARCH && !status.hit && !status.exhausted);

   // result register frees up when empty or being taken
   assign post = state_ff == ST_FINISH && (!rsp_valid_ff || !rsp_stall);

   stbs_table #(
      .DEPTH  (TABLE_DEPTH),
      .ADDR_W (ADDR_W)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (ADDR_W'(req_entry_index)),
      .wr_data (req_value),
      .rd_en   (rd_en),
      .rd_addr (mid_next),
      .rd_data (rd_data)
   );

   stbs_probe #(
      .ADDR_W (ADDR_W),
      .CNT_W  (CNT_W)
   ) u_probe (
      .start      (start),
      .count      (count_sat),
      .key        (key_ff),
      .probe_data (rd_data),
      .lo         (lo_ff),
      .bound      (bound_ff),
      .mid        (mid_ff),
      .lo_next    (lo_next),
      .bound_next (bound_next),
      .mid_next   (mid_next),
      .status     (status)
   );

   // sequencer next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = status.exhausted ? ST_FINISH : ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            if (status.hit || status.exhausted) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (post) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         entry_count_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) begin
            entry_count_ff <= csr_wr_data;
         end
         if (post) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // search datapath registers
   always_ff @(posedge clock) begin
      if (start) begin
         key_ff      <= req_value;
         lo_ff       <= lo_next;
         bound_ff    <= bound_next;
         mid_ff      <= mid_next;
         found_ff    <= 1'b0;
         position_ff <= '0;
      end else if (state_ff == ST_SEARCH) begin
         if (status.hit) begin
            found_ff    <= 1'b1;
            position_ff <= POSITION_W'(mid_ff);
         end else if (status.exhausted) begin
            found_ff    <= 1'b0;
            position_ff <= '0;
         end else begin
            lo_ff    <= lo_next;
            bound_ff <= bound_next;
            mid_ff   <= mid_next;
         end
      end
   end

   // result beat payload
   always_ff @(posedge clock) begin
      if (post) begin
         rsp_found_ff    <= found_ff;
         rsp_position_ff <= position_ff;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_found    = rsp_found_ff;
   assign rsp_position = rsp_position_ff;

   // checks
   `STBS_ASSERT_NEXT(a_search_leaves_idle, clock, reset, start, state_ff != ST_IDLE, "search beat did not start the sequencer")
   `STBS_ASSERT_NOW(a_mid_in_range, clock, reset, state_ff == ST_SEARCH, (lo_ff <= CNT_W'(mid_ff)) && (CNT_W'(mid_ff) < bound_ff), "probe midpoint outside active range")
   `STBS_ASSERT_NOW(a_miss_position_zero, clock, reset, rsp_valid_ff && !rsp_found_ff, rsp_position_ff == '0, "miss result with nonzero position")
   `STBS_ASSERT_NEXT(a_finish_posts, clock, reset, state_ff == ST_FINISH && !(rsp_valid_ff && rsp_stall), rsp_valid_ff && state_ff == ST_IDLE, "finished search did not post its result")

endmodule

// ===== design/stbs_table.sv =====
// Table storage: one write port, one registered read port
module stbs_table #(
   parameter int DEPTH  = 256,
   parameter int ADDR_W = 8
) (
   input  logic                            clock,
   input  logic                            wr_en,
   input  logic [ADDR_W-1:0]               wr_addr,
   input  logic [stbs_pkg::VALUE_W-1:0]    wr_data,
   input  logic                            rd_en,
   input  logic [ADDR_W-1:0]               rd_addr,
   output logic [stbs_pkg::VALUE_W-1:0]    rd_data
);
   import stbs_pkg::*;

   logic [VALUE_W-1:0] table_ff [DEPTH];
   logic [VALUE_W-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         table_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= table_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/stbs_probe.sv =====
// Shared probe unit: compare, narrow the range, pick the next midpoint
module stbs_probe #(
   parameter int ADDR_W = 8,
   parameter int CNT_W  = 9
) (
   input  logic                                  start,
   input  logic [CNT_W-1:0]                      count,
   input  logic signed [stbs_pkg::VALUE_W-1:0]   key,
   input  logic signed [stbs_pkg::VALUE_W-1:0]   probe_data,
   input  logic [CNT_W-1:0]                      lo,
   input  logic [CNT_W-1:0]                      bound,
   input  logic [ADDR_W-1:0]                     mid,
   output logic [CNT_W-1:0]                      lo_next,
   output logic [CNT_W-1:0]                      bound_next,
   output logic [ADDR_W-1:0]                     mid_next,
   output stbs_pkg::probe_status_type            status
);
   import stbs_pkg::*;

   logic             greater;
   logic             less;
   logic [CNT_W-1:0] mid_ext;
   logic [CNT_W:0]   mid_sum;

   // range is [lo, bound); start seeds it with [0, count)
   always_comb begin
      greater = key > probe_data;
      less    = key < probe_data;
      mid_ext = CNT_W'(mid);
      if (start) begin
         lo_next    = '0;
         bound_next = count;
      end else begin
         lo_next    = greater ? mid_ext + CNT_W'(1) : lo;
         bound_next = less ? mid_ext : bound;
      end
      status.hit       = !start && !greater && !less;
      status.exhausted = lo_next >= bound_next;
      // floor((lo + bound - 1) / 2), only used while the range is non-empty
      mid_sum  = {1'b0, lo_next} + {1'b0, bound_next} - (CNT_W+1)'(1);
      mid_next = mid_sum[ADDR_W:1];
   end

endmodule

// ===== bench/tb.sv =====
// Testbench for the sorted table binary search unit: random and directed beats, scoreboard check
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import stbs_pkg::*;

   localparam int TABLE_DEPTH   = DEFAULT_TABLE_DEPTH;
   localparam int TARGET_ITEMS  = 1500;
   localparam int SETTLE_CYCLES = 32;
   localparam int MAX_REPORTS   = 10;
   localparam logic signed [VALUE_W-1:0] VALUE_MIN = 32'sh8000_0000;
   localparam logic signed [VALUE_W-1:0] VALUE_MAX = 32'sh7FFF_FFFF;

   typedef struct packed {
      logic                      op;
      logic [INDEX_W-1:0]        entry_index;
      logic signed [VALUE_W-1:0] value;
   } table_beat_type;

   typedef struct packed {
      logic                  found;
      logic [POSITION_W-1:0] position;
   } lookup_result_type;

   // DUT connections; the driven inputs are known from time zero
   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic                      req_op = OP_WRITE;
   logic [INDEX_W-1:0]        req_entry_index = '0;
   logic signed [VALUE_W-1:0] req_value = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic                      rsp_found;
   logic [POSITION_W-1:0]     rsp_position;
   logic                      csr_wr_en = 1'b0;
   logic [COUNT_W-1:0]        csr_wr_data = '0;

   // Shadow of the block state: table updated at acceptance, entry count at the CSR write
   logic signed [VALUE_W-1:0] table_shadow [TABLE_DEPTH];
   logic [COUNT_W-1:0]        entry_count_shadow = '0;

   // Generator-side view of what the table will hold once queued writes land
   logic signed [VALUE_W-1:0] planned [TABLE_DEPTH];

   table_beat_type    pending_beats [$];
   lookup_result_type expected_lookups [$];
   table_beat_type    driven_beat;
   int                send_gap = 0;
   int                stall_left = 0;
   int                idle_mode = 0;
   int                fail_count = 0;
   int                queued_count = 0;
   lookup_result_type oldest_lookup;

   sorted_table_binary_search_unit #(.TABLE_DEPTH(TABLE_DEPTH)) uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_op          (req_op),
      .req_entry_index (req_entry_index),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_found       (rsp_found),
      .rsp_position    (rsp_position),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data)
   );

   always #1 clock = ~clock;

   // Binary search over the shadow table with the current entry count
   function automatic lookup_result_type search_shadow(logic signed [VALUE_W-1:0] target);
      int lo;
      int hi;
      int mid;
      int span;
      lookup_result_type res;
      res = '0;
      span = (entry_count_shadow > TABLE_DEPTH) ? TABLE_DEPTH : int'(entry_count_shadow);
      lo = 0;
      hi = span - 1;
      while (lo <= hi) begin
         mid = lo + (hi - lo) / 2;
         if (target > table_shadow[mid]) begin
            lo = mid + 1;
         end else if (target < table_shadow[mid]) begin
            hi = mid - 1;
         end else begin
            res.found = 1'b1;
            res.position = mid[POSITION_W-1:0];
            return res;
         end
      end
      return res;
   endfunction

   // Per-beat wait, shaped by the current idle mode
   function automatic int draw_wait();
      case (idle_mode)
         0: return 0;
         1: return ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 10)) : 0;
         default: return int'($urandom_range(0, 10));
      endcase
   endfunction

   function automatic void note_failure(string msg);
      fail_count++;
      if (fail_count <= MAX_REPORTS) $display("%s", msg);
   endfunction

   // Request driver: holds a stalled beat, otherwise pops the next after its gap
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            if (driven_beat.op == OP_WRITE)
               table_shadow[driven_beat.entry_index] = driven_beat.value;
            else
               expected_lookups.push_back(search_shadow(driven_beat.value));
         end
         if (!(req_valid && req_stall)) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (pending_beats.size() > 0) begin
               driven_beat = pending_beats.pop_front();
               req_valid <= 1'b1;
               req_op <= driven_beat.op;
               req_entry_index <= driven_beat.entry_index;
               req_value <= driven_beat.value;
               send_gap = draw_wait();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Result monitor: compare each accepted beat with the oldest expected lookup
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_lookups.size() == 0) begin
               note_failure($sformatf("unexpected result: found=%0d position=%0d",
                                      rsp_found, rsp_position));
            end else begin
               oldest_lookup = expected_lookups.pop_front();
               if (rsp_found !== oldest_lookup.found ||
                   rsp_position !== oldest_lookup.position)
                  note_failure($sformatf("mismatch: found exp %0d got %0d, position exp %0d got %0d",
                                         oldest_lookup.found, rsp_found,
                                         oldest_lookup.position, rsp_position));
            end
            stall_left = draw_wait();
         end
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic queue_write(int idx, logic signed [VALUE_W-1:0] val);
      table_beat_type b;
      b.op = OP_WRITE;
      b.entry_index = idx[INDEX_W-1:0];
      b.value = val;
      planned[idx] = val;
      pending_beats.push_back(b);
      queued_count++;
   endtask

   task automatic queue_search(logic signed [VALUE_W-1:0] target);
      table_beat_type b;
      b.op = OP_SEARCH;
      b.entry_index = INDEX_W'($urandom);
      b.value = target;
      pending_beats.push_back(b);
      queued_count++;
   endtask

   // Wait until every beat is sent and answered, then let trailing writes finish
   task automatic wait_drained();
      do @(negedge clock);
      while (pending_beats.size() > 0 || req_valid || expected_lookups.size() > 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_entry_count(int c);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= c[COUNT_W-1:0];
      @(posedge clock);
      csr_wr_en <= 1'b0;
      entry_count_shadow = c[COUNT_W-1:0];
   endtask

   // Ascending contents for entries 0..n-1; narrow spacing gives duplicates and near misses
   task automatic fill_ascending(int n, bit narrow);
      longint acc;
      longint step_max;
      if (narrow) begin
         step_max = 2;
         acc = ($urandom_range(0, 7) == 0) ? longint'(VALUE_MIN)
                                           : longint'(signed'(32'($urandom)));
      end else begin
         step_max = 64'h1_0000_0000 / (n + 1);
         acc = longint'(VALUE_MIN) + longint'($urandom_range(0, 32'(step_max)));
      end
      for (int i = 0; i < n; i++) begin
         if (acc > longint'(VALUE_MAX)) acc = longint'(VALUE_MAX);
         queue_write(i, acc[VALUE_W-1:0]);
         acc += longint'($urandom_range(0, 32'(step_max)));
      end
   endtask

   function automatic logic signed [VALUE_W-1:0] pick_target(int n);
      int roll;
      roll = $urandom_range(0, 19);
      if (n > 0 && roll < 12) return planned[$urandom_range(0, n - 1)];
      if (n > 0 && roll < 14) return planned[$urandom_range(0, n - 1)] + 1;
      if (n > 0 && roll < 16) return planned[$urandom_range(0, n - 1)] - 1;
      if (roll == 16) return VALUE_MIN;
      if (roll == 17) return VALUE_MAX;
      return signed'(32'($urandom));
   endfunction

   // Searches over the first n entries, with the odd rewrite mixed in
   task automatic queue_lookups(int n, int k);
      for (int j = 0; j < k; j++) begin
         if (n > 0 && $urandom_range(0, 24) == 0)
            queue_write($urandom_range(0, n - 1), signed'(32'($urandom)));
         queue_search(pick_target(n));
      end
   endtask

   // Stimulus
   initial begin
      int n;
      int c;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty table, field extremes, hits at both ends, misses between
      queue_search(32'sd0);
      queue_search(VALUE_MAX);
      queue_write(0, VALUE_MIN);
      queue_write(1, -32'sd1);
      queue_write(2, 32'sd0);
      queue_write(3, 32'sd3);
      queue_write(4, VALUE_MAX);
      queue_write(255, 32'sh5555_AAAA);
      wait_drained();
      write_entry_count(5);
      queue_search(VALUE_MIN);
      queue_search(-32'sd1);
      queue_search(32'sd0);
      queue_search(32'sd3);
      queue_search(VALUE_MAX);
      queue_search(32'sd2);
      queue_search(VALUE_MIN + 1);
      queue_search(VALUE_MAX - 1);
      queue_search(-32'sd2);
      wait_drained();
      write_entry_count(1);
      queue_search(VALUE_MIN);
      queue_search(VALUE_MAX);
      queue_search(32'sd0);

      // Full table, then counts at and beyond the depth
      wait_drained();
      idle_mode = 1;
      write_entry_count(TABLE_DEPTH);
      fill_ascending(TABLE_DEPTH, 1'b0);
      queue_search(planned[0]);
      queue_search(planned[TABLE_DEPTH - 1]);
      queue_search(planned[TABLE_DEPTH / 2]);
      queue_lookups(TABLE_DEPTH, 40);
      wait_drained();
      idle_mode = 2;
      write_entry_count((1 << COUNT_W) - 1);
      queue_search(planned[TABLE_DEPTH - 1]);
      queue_lookups(TABLE_DEPTH, 30);
      wait_drained();
      idle_mode = 0;
      write_entry_count($urandom_range(TABLE_DEPTH + 1, (1 << COUNT_W) - 2));
      queue_lookups(TABLE_DEPTH, 20);
      wait_drained();
      write_entry_count(0);
      queue_lookups(0, 8);

      // Random phases: mostly small sorted tables with random contents
      while (queued_count < TARGET_ITEMS) begin
         wait_drained();
         idle_mode = $urandom_range(0, 2);
         c = $urandom_range(0, 9);
         if (c < 7) n = $urandom_range(1, 16);
         else if (c < 9) n = $urandom_range(17, 64);
         else n = $urandom_range(65, TABLE_DEPTH);
         write_entry_count(n);
         fill_ascending(n, $urandom_range(0, 2) == 0);
         // Break the ordering now and then
         if ($urandom_range(0, 4) == 0) begin
            repeat ($urandom_range(1, 3))
               queue_write($urandom_range(0, n - 1), signed'(32'($urandom)));
         end
         // Writes above the active range are harmless noise
         if (n < TABLE_DEPTH && $urandom_range(0, 3) == 0)
            queue_write($urandom_range(n, TABLE_DEPTH - 1), signed'(32'($urandom)));
         queue_lookups(n, $urandom_range(10, 40));
      end

      wait_drained();
      if (fail_count == 0) begin
         $display("sorted_table_binary_search_unit test passed");
      end else begin
         $display("sorted_table_binary_search_unit test failed");
      end
      $finish;
   end

   // Run limit
   initial begin
      #2000000;
      $display("sorted_table_binary_search_unit test failed");
      $finish;
   end

endmodule
